@@ src/swef_pkg.sv @@
`timescale 1ns / 1ps

package swef_pkg;

  localparam int PIXEL_W = 8;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 11;
  localparam int OFF_W = 3;
  // wide enough to hold any frame size limit plus one
  localparam int DIM_W = 14;

  localparam int DEF_WINDOW = 7;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 12'd1280;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd1024;

endpackage

@@ src/swef_pixel_if.sv @@
`timescale 1ns / 1ps

interface swef_pixel_if;
  import swef_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic               frame_start;

  modport source(output valid, pixel_value, frame_start, input ready);
  modport sink(input valid, pixel_value, frame_start, output ready);
endinterface

@@ src/swef_result_if.sv @@
`timescale 1ns / 1ps

interface swef_result_if;
  import swef_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ROW_OUT_W-1:0]        center_row;
  logic [COL_OUT_W-1:0]        center_col;
  logic signed [OFF_W-1:0]     dark_offset;
  logic signed [OFF_W-1:0]     bright_offset;
  logic                        frame_done;

  modport source(output valid, center_row, center_col, dark_offset, bright_offset, frame_done,
                 input ready);
  modport sink(input valid, center_row, center_col, dark_offset, bright_offset, frame_done,
               output ready);
endinterface

@@ src/stripe_window_extremum_finder.sv @@
`timescale 1ns / 1ps

// Stripe window extremum finder. Takes one grey pixel per clock in raster order and, for
// each pixel whose WINDOW x WINDOW window lies inside the image, delivers one result with
// the window centre and the offsets of the first brightest and first darkest column sum.
// Border pixels give no result. Throughput is one pixel per cycle; the line store, one
// word per image column holding the last WINDOW-1 lines, is read and rewritten once per
// pixel through its single read and single write port. A result is registered in stage 1,
// stage 2 and the output register after its pixel is accepted. The input stalls only
// while a result waits untaken in the output register. No start-up sweep: the line
// store needs no clearing since every result uses only words written earlier in its frame.
module stripe_window_extremum_finder #(
  parameter int WINDOW = swef_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = swef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = swef_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [swef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swef_pkg::CFG_W-1:0]     cfg_data,
  swef_pixel_if.sink                     pixels,
  swef_result_if.source                  results
);
  import swef_pkg::*;

  localparam int HALF = WINDOW / 2;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int SUM_W = $clog2(WINDOW * 255 + 1);
  localparam int IDX_W = $clog2(WINDOW);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic [DIM_W-1:0] c_ext;
  logic [DIM_W-1:0] r_ext;

  logic adv;
  logic accept;
  logic emit0;
  logic done0;

  logic                 s1_valid;
  logic [COL_W-1:0]     s1_col;
  logic [PIXEL_W-1:0]   s1_pixel;
  logic                 s1_emit;
  logic                 s1_done;
  logic [ROW_OUT_W-1:0] s1_crow;
  logic [COL_OUT_W-1:0] s1_ccol;

  logic                 s2_emit;
  logic                 s2_done;
  logic [ROW_OUT_W-1:0] s2_crow;
  logic [COL_OUT_W-1:0] s2_ccol;

  logic                 out_valid;
  logic [ROW_OUT_W-1:0] out_crow;
  logic [COL_OUT_W-1:0] out_ccol;
  logic [OFF_W-1:0]     out_dark;
  logic [OFF_W-1:0]     out_bright;
  logic                 out_done;

  logic [SUM_W-1:0] col_sum;
  logic [SUM_W-1:0] win [WINDOW];
  logic [IDX_W-1:0] bright_idx;
  logic [IDX_W-1:0] dark_idx;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(image_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(image_height);
    end
  end

  // ---- flow control: whole pipe moves when the output register can take ----
  assign adv = !out_valid || results.ready;
  assign pixels.ready = adv;
  assign accept = pixels.valid && adv;

  // ---- position of the incoming pixel ----
  assign c_cur = pixels.frame_start ? '0 : col_count;
  assign r_cur = pixels.frame_start ? '0 : row_count;
  assign c_ext = DIM_W'(c_cur);
  assign r_ext = DIM_W'(r_cur);

  assign emit0 = (r_ext >= DIM_W'(WINDOW - 1)) && (c_ext >= DIM_W'(WINDOW - 1)) &&
                 (r_ext < h_eff) && (c_ext < w_eff);
  assign done0 = (r_ext == h_eff - DIM_W'(1)) && (c_ext == w_eff - DIM_W'(1));

  always_comb begin
    if (c_ext + DIM_W'(1) >= w_eff) begin
      col_count_next = '0;
      row_count_next = (r_ext + DIM_W'(1) >= h_eff) ? '0 : ROW_W'(r_ext + DIM_W'(1));
    end else begin
      col_count_next = COL_W'(c_ext + DIM_W'(1));
      row_count_next = (r_ext >= h_eff) ? '0 : r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---- stage 1: line store read returns, column sum formed ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col <= c_cur;
      s1_pixel <= pixels.pixel_value;
      s1_emit <= emit0;
      s1_done <= done0;
      s1_crow <= ROW_OUT_W'(r_ext - DIM_W'(HALF));
      s1_ccol <= COL_OUT_W'(c_ext - DIM_W'(HALF));
    end
  end

  swef_line_store #(
    .WINDOW(WINDOW),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .rd_col(c_cur),
    .wr_valid(s1_valid),
    .wr_col(s1_col),
    .wr_pixel(s1_pixel),
    .col_sum(col_sum)
  );

  // column sum window, oldest at index 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        win[k] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WINDOW-1] <= col_sum;
    end
  end

  // ---- stage 2: window holds this item's sums, pick extremes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else if (adv) begin
      s2_emit <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_done <= s1_done;
      s2_crow <= s1_crow;
      s2_ccol <= s1_ccol;
    end
  end

  swef_extremum #(
    .WINDOW(WINDOW)
  ) u_extremum (
    .sums(win),
    .bright_idx(bright_idx),
    .dark_idx(dark_idx)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_crow <= s2_crow;
      out_ccol <= s2_ccol;
      out_done <= s2_done;
      out_dark <= OFF_W'(dark_idx) - OFF_W'(HALF);
      out_bright <= OFF_W'(bright_idx) - OFF_W'(HALF);
    end
  end

  assign results.valid = out_valid;
  assign results.center_row = out_crow;
  assign results.center_col = out_ccol;
  assign results.dark_offset = out_dark;
  assign results.bright_offset = out_bright;
  assign results.frame_done = out_done;

  // sums of never-written store columns are unknown, so compare with ===
`ifndef SYNTHESIS
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (win[WINDOW-1] === $past(win[WINDOW-1])) && (win[0] === $past(win[0])))
    else $error("column sum window moved during a stall");

  a_win_load: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid |=> win[WINDOW-1] === $past(col_sum))
    else $error("newest window entry is not the column sum of the item");

  a_emit_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit |-> DIM_W'(s1_col) >= DIM_W'(WINDOW - 1))
    else $error("result flagged for a border column");

  a_done_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_crow == ROW_OUT_W'(h_eff - DIM_W'(1 + HALF)))
    else $error("frame end result not on the last interior row");
`endif

endmodule

@@ src/swef_line_store.sv @@
`timescale 1ns / 1ps

module swef_line_store #(
  parameter int WINDOW = swef_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = swef_pkg::DEF_MAX_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    adv,
  input  logic [$clog2(MAX_WIDTH)-1:0]            rd_col,
  input  logic                                    wr_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]            wr_col,
  input  logic [swef_pkg::PIXEL_W-1:0]            wr_pixel,
  output logic [$clog2(WINDOW*255+1)-1:0]         col_sum
);
  import swef_pkg::*;

  localparam int STORE_ROWS = WINDOW - 1;
  localparam int WORD_W = STORE_ROWS * PIXEL_W;
  localparam int SUM_W = $clog2(WINDOW * 255 + 1);

  // one word per column: row 0 is the newest stored line
  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] wdata;

  assign word = fwd ? fwd_data : rdata;
  assign wdata = {word[WORD_W-PIXEL_W-1:0], wr_pixel};

  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = SUM_W'(wr_pixel);
    for (int k = 0; k < STORE_ROWS; k++) begin
      acc = acc + SUM_W'(word[k*PIXEL_W +: PIXEL_W]);
    end
    col_sum = acc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[rd_col];
      fwd_data <= wdata;
      if (wr_valid) begin
        mem[wr_col] <= wdata;
      end
    end
  end

  // read and write of the same column at one edge: take the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (adv) begin
      fwd <= wr_valid && (wr_col == rd_col);
    end
  end

endmodule

@@ src/swef_extremum.sv @@
`timescale 1ns / 1ps

module swef_extremum #(
  parameter int WINDOW = swef_pkg::DEF_WINDOW
) (
  input  logic [$clog2(WINDOW*255+1)-1:0] sums [WINDOW],
  output logic [$clog2(WINDOW)-1:0]       bright_idx,
  output logic [$clog2(WINDOW)-1:0]       dark_idx
);
  import swef_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * 255 + 1);
  localparam int IDX_W = $clog2(WINDOW);
  localparam int LV = IDX_W;
  localparam int NP = 1 << IDX_W;

  logic [SUM_W-1:0] hi_val [LV+1][NP];
  logic [SUM_W-1:0] lo_val [LV+1][NP];
  logic [IDX_W-1:0] hi_idx [LV+1][NP];
  logic [IDX_W-1:0] lo_idx [LV+1][NP];
  logic             ok     [LV+1][NP];

  // pairwise tree; on a tie the left (lower index) side wins
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int n = 0; n < NP; n++) begin
        hi_val[l][n] = '0;
        lo_val[l][n] = '0;
        hi_idx[l][n] = '0;
        lo_idx[l][n] = '0;
        ok[l][n] = 1'b0;
      end
    end
    for (int n = 0; n < WINDOW; n++) begin
      hi_val[0][n] = sums[n];
      lo_val[0][n] = sums[n];
      hi_idx[0][n] = IDX_W'(n);
      lo_idx[0][n] = IDX_W'(n);
      ok[0][n] = 1'b1;
    end
    for (int l = 1; l <= LV; l++) begin
      for (int n = 0; n < (NP >> l); n++) begin
        ok[l][n] = ok[l-1][2*n] || ok[l-1][2*n+1];
        if (ok[l-1][2*n+1] && (!ok[l-1][2*n] || hi_val[l-1][2*n+1] > hi_val[l-1][2*n])) begin
          hi_val[l][n] = hi_val[l-1][2*n+1];
          hi_idx[l][n] = hi_idx[l-1][2*n+1];
        end else begin
          hi_val[l][n] = hi_val[l-1][2*n];
          hi_idx[l][n] = hi_idx[l-1][2*n];
        end
        if (ok[l-1][2*n+1] && (!ok[l-1][2*n] || lo_val[l-1][2*n+1] < lo_val[l-1][2*n])) begin
          lo_val[l][n] = lo_val[l-1][2*n+1];
          lo_idx[l][n] = lo_idx[l-1][2*n+1];
        end else begin
          lo_val[l][n] = lo_val[l-1][2*n];
          lo_idx[l][n] = lo_idx[l-1][2*n];
        end
      end
    end
  end

  assign bright_idx = hi_idx[LV][0];
  assign dark_idx = lo_idx[LV][0];

endmodule
